[design/sector_cache_lru_writeback_macros.svh]
// ---------------------------------------------------------------------------
// Sector cache assertion macros
// Shared assertion forms for the sector cache checker.
// ---------------------------------------------------------------------------
`ifndef SECTOR_CACHE_LRU_WRITEBACK_MACROS_SVH
`define SECTOR_CACHE_LRU_WRITEBACK_MACROS_SVH

// implication checked on every edge outside reset
`define SC_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("sector cache check failed");

// next-cycle implication checked outside reset
`define SC_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("sector cache check failed");

`endif

[design/scache_pkg.sv]
// ---------------------------------------------------------------------------
// Sector cache package
// Constants, types and command/status structs shared by the cache modules.
// ---------------------------------------------------------------------------
package scache_pkg;

  localparam int Entries = 256;
  localparam int IdxW = $clog2(Entries);
  localparam int CntW = $clog2(Entries + 1);

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  localparam logic [1:0] ST_HIT     = 2'd0;
  localparam logic [1:0] ST_FILLED  = 2'd1;
  localparam logic [1:0] ST_FAILED  = 2'd2;
  localparam logic [1:0] ST_CLEARED = 2'd3;

  localparam logic [7:0] ALL_DISKS = 8'hFF;

  typedef struct packed {
    logic load;        // capture request, reset scan
    logic scan;        // step one slot of the scan
    logic hit_upd;     // refresh hit slot
    logic evict;       // invalidate victim
    logic fill;        // write fill slot
    logic wb_clear;    // zero writeback fields
    logic clr_reset;   // zero clear count
  } scache_cmd_t;

  typedef struct packed {
    logic scan_last;   // scan counter has passed the last slot
    logic hit;         // match found
    logic have_victim;
    logic have_free;
    logic full;
  } scache_sts_t;

endpackage

[design/sector_cache_lru_writeback.sv]
// Clear and lookup scan all 256 slots in turn; op three skips the scan and goes
// straight to the result state.
// Flow: one item at a time; the next input is taken the cycle after the
// result transaction, as the serial tag scan keeps the block busy until then.
// Reset: rst synchronous active high empties the cache and zeroes the stamp.
// ---------------------------------------------------------------------------
// Sector cache top level
// Fully associative LRU write-back tag engine keyed by disk and sector.
// ---------------------------------------------------------------------------
module sector_cache_lru_writeback import scache_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [1:0] operation, [9:2] disk_number, [41:10] sector_number, [47:42] zero
  input  logic [47:0] s_tdata,
  // [0] sector_available
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [1:0] status, [9:2] slot_index, [10] writeback_valid,
  // [18:11] writeback_disk, [50:19] writeback_sector, [59:51] cleared_count,
  // [63:60] zero
  output logic [63:0] m_tdata
);

  scache_cmd_t     cmd;
  scache_sts_t     sts;
  logic [IdxW-1:0] hit_slot;
  logic [IdxW-1:0] free_slot;
  logic            wb_valid;
  logic [7:0]      wb_disk;
  logic [31:0]     wb_sector;
  logic [CntW-1:0] clr_count;
  logic [1:0]      status;
  logic            slot_sel_hit;
  logic            result_clear;
  logic [7:0]      slot_out;

  scache_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready),
    .operation(s_tdata[1:0]), .sector_available(s_tuser),
    .cmd(cmd), .sts(sts),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .status(status), .slot_sel_hit(slot_sel_hit), .result_clear(result_clear)
  );

  scache_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .operation(s_tdata[1:0]), .disk_number(s_tdata[9:2]),
    .sector_number(s_tdata[41:10]),
    .hit_slot(hit_slot), .free_slot(free_slot),
    .wb_valid(wb_valid), .wb_disk(wb_disk), .wb_sector(wb_sector),
    .clr_count(clr_count)
  );

  assign slot_out = result_clear ? 8'd0 :
                    8'(slot_sel_hit ? hit_slot : free_slot);

  assign m_tdata = {4'd0, 9'(clr_count), wb_sector, wb_disk, wb_valid,
                    slot_out, status};

endmodule

[design/scache_datapath.sv]
// ---------------------------------------------------------------------------
// Sector cache datapath
// Tag memories, per-slot valid/dirty flags, serial scan and result fields.
// ---------------------------------------------------------------------------
module scache_datapath import scache_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  scache_cmd_t       cmd,
  output scache_sts_t       sts,
  input  logic [1:0]        operation,
  input  logic [7:0]        disk_number,
  input  logic [31:0]       sector_number,
  output logic [IdxW-1:0]   hit_slot,
  output logic [IdxW-1:0]   free_slot,
  output logic              wb_valid,
  output logic [7:0]        wb_disk,
  output logic [31:0]       wb_sector,
  output logic [CntW-1:0]   clr_count
);

  logic [Entries-1:0] valid;
  logic [Entries-1:0] dirty;
  logic [7:0]         tag_disk  [Entries];
  logic [31:0]        tag_sector[Entries];
  logic [31:0]        use_stamp [Entries];

  logic [1:0]      op;
  logic [7:0]      disk;
  logic [31:0]     sector;
  logic [31:0]     stamp;
  logic [CntW-1:0] count;
  logic [CntW-1:0] scan_cnt;
  logic [IdxW-1:0] idx;
  logic            scan_started;
  logic [IdxW-1:0] rd_idx;
  logic            rd_valid;
  logic [7:0]      rd_disk;
  logic [31:0]     rd_sector;
  logic [31:0]     rd_stamp;
  logic            hit;
  logic            have_victim;
  logic [IdxW-1:0] victim;
  logic [31:0]     victim_stamp;
  logic [7:0]      victim_disk;
  logic [31:0]     victim_sector;
  logic            have_free;
  logic            rd_match;
  logic            rd_clear;

  assign idx = scan_cnt[IdxW-1:0];

  always_ff @(posedge clk) begin
    rd_disk   <= tag_disk[idx];
    rd_sector <= tag_sector[idx];
    rd_stamp  <= use_stamp[idx];
    if (cmd.fill) begin
      tag_disk[free_slot]   <= disk;
      tag_sector[free_slot] <= sector;
      use_stamp[free_slot]  <= stamp + 32'd2;
    end else if (cmd.hit_upd) begin
      use_stamp[hit_slot] <= stamp + 32'd1;
    end
  end

  assign rd_match = rd_valid && rd_disk == disk && rd_sector == sector;
  assign rd_clear = rd_valid && (disk == ALL_DISKS || rd_disk == disk);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      dirty <= '0;
      stamp <= '0;
      count <= '0;
      scan_cnt <= '0;
      scan_started <= 1'b0;
      hit <= 1'b0;
      have_victim <= 1'b0;
      have_free <= 1'b0;
    end else begin
      if (cmd.load) begin
        op <= operation;
        disk <= disk_number;
        sector <= sector_number;
        scan_cnt <= '0;
        scan_started <= 1'b0;
        hit <= 1'b0;
        have_victim <= 1'b0;
        have_free <= 1'b0;
      end else if (cmd.scan) begin
        scan_cnt <= scan_cnt + 1'b1;
        scan_started <= 1'b1;
        rd_idx <= idx;
        rd_valid <= valid[idx];
        if (!valid[idx] && !have_free) begin
          have_free <= 1'b1;
          free_slot <= idx;
        end
        if (scan_started) begin
          if (op == OP_CLEAR) begin
            if (rd_clear) begin
              valid[rd_idx] <= 1'b0;
              dirty[rd_idx] <= 1'b0;
              clr_count <= clr_count + 1'b1;
              count <= count - 1'b1;
            end
          end else begin
            if (rd_match && !hit) begin
              hit <= 1'b1;
              hit_slot <= rd_idx;
            end
            if (rd_valid && (!have_victim || rd_stamp < victim_stamp)) begin
              have_victim <= 1'b1;
              victim <= rd_idx;
              victim_stamp <= rd_stamp;
              victim_disk <= rd_disk;
              victim_sector <= rd_sector;
            end
          end
        end
      end
      if (cmd.clr_reset) begin
        clr_count <= '0;
      end
      if (cmd.wb_clear) begin
        wb_valid <= 1'b0;
        wb_disk <= '0;
        wb_sector <= '0;
      end
      if (cmd.hit_upd) begin
        stamp <= stamp + 32'd1;
        if (op == OP_WRITE) begin
          dirty[hit_slot] <= 1'b1;
        end
      end
      if (cmd.evict) begin
        valid[victim] <= 1'b0;
        dirty[victim] <= 1'b0;
        count <= count - 1'b1;
        wb_valid <= dirty[victim];
        wb_disk <= dirty[victim] ? victim_disk : 8'd0;
        wb_sector <= dirty[victim] ? victim_sector : 32'd0;
        free_slot <= victim;
        have_free <= 1'b1;
      end
      if (cmd.fill) begin
        stamp <= stamp + 32'd2;
        valid[free_slot] <= 1'b1;
        dirty[free_slot] <= (op == OP_WRITE);
        if (have_free) begin
          count <= count + 1'b1;
        end
      end
    end
  end

  assign sts.scan_last   = scan_started && (scan_cnt == CntW'(Entries));
  assign sts.hit         = hit;
  assign sts.have_victim = have_victim;
  assign sts.have_free   = have_free;
  assign sts.full        = (count >= CntW'(Entries));

endmodule

[design/scache_ctrl.sv]
// ---------------------------------------------------------------------------
// Sector cache controller
// Sequences scan, hit update, eviction, fill and result handshake.
// ---------------------------------------------------------------------------
module scache_ctrl import scache_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic        sector_available,
  output scache_cmd_t cmd,
  input  scache_sts_t sts,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic        slot_sel_hit,
  output logic        result_clear
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_EVICT = 3'd2;
  localparam logic [2:0] S_FILL  = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [1:0] op;
  logic       avail;

  assign in_ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load = 1'b1;
          cmd.wb_clear = 1'b1;
          cmd.clr_reset = 1'b1;
          state_next = (operation == OP_NOP) ? S_OUT : S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_last) begin
          cmd.scan = 1'b1;
          if (op == OP_CLEAR) begin
            state_next = S_OUT;
          end else begin
            state_next = S_EVICT;
          end
        end else begin
          cmd.scan = 1'b1;
        end
      end
      S_EVICT: begin
        if (sts.hit) begin
          cmd.hit_upd = 1'b1;
          state_next = S_OUT;
        end else begin
          cmd.evict = sts.full && sts.have_victim;
          state_next = avail ? S_FILL : S_OUT;
        end
      end
      S_FILL: begin
        cmd.fill = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: state_next = S_OUT;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      status <= ST_HIT;
      slot_sel_hit <= 1'b0;
      result_clear <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == S_OUT) begin
        state <= S_IDLE;
        out_valid <= 1'b1;
      end else begin
        state <= state_next;
      end
      if (cmd.load) begin
        op <= operation;
        avail <= sector_available;
        result_clear <= 1'b1;
        if (operation[1]) begin
          status <= ST_CLEARED;
        end
      end
      if (state == S_EVICT) begin
        if (sts.hit) begin
          status <= ST_HIT;
          slot_sel_hit <= 1'b1;
          result_clear <= 1'b0;
        end else if (avail) begin
          status <= ST_FILLED;
          slot_sel_hit <= 1'b0;
          result_clear <= 1'b0;
        end else begin
          status <= ST_FAILED;
        end
      end
    end
  end

endmodule

[design/sector_cache_lru_writeback_checker.sv]
// ---------------------------------------------------------------------------
// Sector cache port checker
// Port-level checks on the result stream and input ready, bound to the top level.
// ---------------------------------------------------------------------------
`include "sector_cache_lru_writeback_macros.svh"

module sector_cache_lru_writeback_checker import scache_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata
);

  `SC_ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `SC_ASSERT_IMP(a_busy, clk, rst, m_tvalid, !s_tready)
  `SC_ASSERT_IMP(a_hit_nowb, clk, rst, m_tvalid && m_tdata[1:0] == ST_HIT, !m_tdata[10])
  `SC_ASSERT_IMP(a_clr_fields, clk, rst, m_tvalid && m_tdata[1:0] == ST_CLEARED,
                 m_tdata[50:2] == '0)

endmodule

bind sector_cache_lru_writeback sector_cache_lru_writeback_checker u_checker (
  .clk(clk), .rst(rst), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
